// File: rtl/ema_steering_thrust_split_core_defines.svh
// assertion macros for the ema steering thrust split block
// depends on nothing; included by modules that check their own logic
`ifndef EMA_STEERING_THRUST_SPLIT_CORE_DEFINES_SVH
`define EMA_STEERING_THRUST_SPLIT_CORE_DEFINES_SVH

// implication checked at every edge outside reset
`define EST_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("check failed");

// next-cycle implication checked outside reset
`define EST_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("check failed");

`endif

// File: rtl/est_pkg.sv
// shared types, constants and rom function for the ema steering block
// depends on nothing
package est_pkg;

    localparam int ALPHA_ENTRIES_DEF = 256;
    localparam int X_FRAC_BITS_DEF = 8;
    localparam int X_INT_BITS = 12;
    localparam int TS_W = 32;
    localparam int TC_W = 24;
    localparam int DB_W = 11;
    localparam int PWR_W = 17;
    localparam int MODE_W = 3;
    localparam logic [PWR_W-1:0] POWER_ONE = 17'd65536;
    localparam logic [PWR_W-1:0] POWER_HALF = 17'd32768;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

    localparam logic [1:0] ADDR_FRAME_WIDTH = 2'd0;
    localparam logic [1:0] ADDR_TIME_CONST = 2'd1;
    localparam logic [1:0] ADDR_DEADBAND = 2'd2;

    typedef enum logic [2:0] {
        MODE_HELD = 3'd0,
        MODE_FIRST = 3'd1,
        MODE_TRACK = 3'd2,
        MODE_DEADBAND = 3'd3,
        MODE_OUT = 3'd4
    } mode_t;

    // item classification handed from front to back
    typedef enum logic [1:0] {
        CLS_HELD = 2'd0,
        CLS_FIRST = 2'd1,
        CLS_FILTER = 2'd2
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_IDX = 3'd1,
        ST_MUL = 3'd2,
        ST_SUM = 3'd3,
        ST_DIV = 3'd4,
        ST_OUT = 3'd5
    } back_state_t;

    // elaboration-time rom entry: 1-exp(-i/32) in q0.16
    function automatic logic [16:0] alpha_entry(input int idx);
        logic [63:0] e;
        logic [63:0] a;
        e = 64'h1_0000_0000;
        for (int i = 0; i < idx; i++) begin
            e = ((e * EXP_STEP_Q32) + 64'h8000_0000) >> 32;
        end
        a = (64'h1_0000_0000 - e + 64'h8000) >> 16;
        return a[16:0];
    endfunction

endpackage

// File: rtl/est_front.sv
// front part: accepts items, classifies them against the stored target
// depends on est_pkg
module est_front #(
    parameter int XW = 20
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [11:0]              in_x,
    input  logic [31:0]              in_ts,
    input  logic [XW-1:0]            filt_x,
    input  logic                     filt_busy,
    output logic                     q_valid,
    input  logic                     q_ready,
    output est_pkg::cls_t            q_cls,
    output logic [11:0]              q_x,
    output logic [31:0]              q_ts
);
    // one-entry queue; any queued or in-flight item blocks acceptance of the next until the back is idle
    logic          full_reg, full_next;
    est_pkg::cls_t cls_reg;
    logic [11:0]   x_reg;
    logic [31:0]   ts_reg;
    logic [XW-1:0] xq;
    logic          take;

    assign xq = XW'({in_x, {(XW-12){1'b0}}});
    assign in_ready = (!full_reg || q_ready) && !filt_busy;
    assign take = in_valid && in_ready;
    assign q_valid = full_reg;
    assign q_cls = cls_reg;
    assign q_x = x_reg;
    assign q_ts = ts_reg;

    always_comb begin
        full_next = full_reg;
        if (q_ready && full_reg) full_next = 1'b0;
        if (take) full_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
        if (take) begin
            x_reg <= in_x;
            ts_reg <= in_ts;
            if (in_x == 12'd0 || xq == filt_x) cls_reg <= est_pkg::CLS_HELD;
            else if (filt_x == '0) cls_reg <= est_pkg::CLS_FIRST;
            else cls_reg <= est_pkg::CLS_FILTER;
        end
    end
endmodule

// File: rtl/est_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on nothing
module est_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    assign quo = q_reg;
    assign done = done_reg;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start) begin
            q_next = num;
            r_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) d_reg <= den;
    end
endmodule

// File: rtl/est_back.sv
// back part: ema filter, region tests and power ratio, plus state
// depends on est_pkg, est_div and the defines header
`include "ema_steering_thrust_split_core_defines.svh"
module est_back #(
    parameter int ALPHA_ENTRIES = est_pkg::ALPHA_ENTRIES_DEF,
    parameter int X_FRAC_BITS = est_pkg::X_FRAC_BITS_DEF,
    parameter int XW = 12 + X_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  est_pkg::cls_t        q_cls,
    input  logic [11:0]          q_x,
    input  logic [31:0]          q_ts,
    input  logic [11:0]          frame_width,
    input  logic [23:0]          time_constant,
    input  logic [10:0]          deadband,
    output logic [XW-1:0]        filt_x,
    output logic                 filt_busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [16:0]          m_left,
    output logic [16:0]          m_right,
    output logic [2:0]           m_mode
);
    localparam int AIW = $clog2(ALPHA_ENTRIES);
    localparam int NW = XW + 17;   // ratio numerator width
    localparam int DW = XW;        // ratio denominator width
    localparam int QNW = 37;       // dt*32 width

    typedef logic [16:0] alpha_arr_t [ALPHA_ENTRIES];
    function automatic alpha_arr_t build_rom();
        alpha_arr_t r;
        for (int i = 0; i < ALPHA_ENTRIES; i++) r[i] = est_pkg::alpha_entry(i);
        return r;
    endfunction
    localparam alpha_arr_t ALPHA_ROM = build_rom();

    est_pkg::back_state_t st_reg, st_next;
    logic [XW-1:0] f_reg, f_next;
    logic [31:0]   lts_reg, lts_next;
    logic [16:0]   hl_reg, hl_next, hr_reg, hr_next;
    logic [2:0]    mode_reg, mode_next;
    logic          ov_reg, ov_next;
    logic [16:0]   ol_reg, ol_next, or_reg, or_next;
    logic [2:0]    om_reg, om_next;
    logic [XW-1:0] xq_reg, xq_next;
    logic [16:0]   a_reg, a_next;
    logic [XW+16:0] p1_reg, p1_next, p2_reg, p2_next;
    logic          dstart;
    logic [47:0]   dnum;
    logic [31:0]   dden;
    logic          ddone;
    logic [47:0]   dquo;
    logic          div_idx_reg, div_idx_next;
    logic [XW+17:0] sum;
    logic [XW-1:0] fn;
    logic [XW:0]   wq, band;
    logic [47:0]   rq;

    est_div #(.NW(48), .DW(32)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .num(dnum),
        .den(dden), .done(ddone), .quo(dquo)
    );

    assign filt_x = f_reg;
    assign filt_busy = (st_reg != est_pkg::ST_IDLE) || q_valid;
    assign m_valid = ov_reg;
    assign m_left = ol_reg;
    assign m_right = or_reg;
    assign m_mode = om_reg;
    assign wq = (XW+1)'({frame_width, {X_FRAC_BITS{1'b0}}});
    assign sum = (XW+18)'(p1_reg) + (XW+18)'(p2_reg) + (XW+18)'(32768);
    assign fn = sum[XW+15:16];
    assign band = (XW+1)'({deadband, {(X_FRAC_BITS+1){1'b0}}});
    assign rq = dquo + {47'd0, 1'b0};

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            est_pkg::ST_IDLE: begin
                if (q_valid && !ov_reg) begin
                    if (q_cls == est_pkg::CLS_FILTER) begin
                        st_next = (time_constant == '0) ? est_pkg::ST_MUL : est_pkg::ST_IDX;
                    end else if (q_cls == est_pkg::CLS_FIRST && frame_width != '0) begin
                        st_next = est_pkg::ST_DIV;
                    end else begin
                        st_next = est_pkg::ST_OUT;
                    end
                end
            end
            est_pkg::ST_IDX: if (ddone) st_next = est_pkg::ST_MUL;
            est_pkg::ST_MUL: st_next = est_pkg::ST_SUM;
            est_pkg::ST_SUM: st_next = est_pkg::ST_DIV;
            est_pkg::ST_DIV: if (ddone || !div_idx_reg) st_next = est_pkg::ST_OUT;
            est_pkg::ST_OUT: st_next = est_pkg::ST_IDLE;
            default: st_next = est_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        f_next = f_reg; lts_next = lts_reg; hl_next = hl_reg; hr_next = hr_reg;
        mode_next = mode_reg; ov_next = ov_reg; ol_next = ol_reg; or_next = or_reg;
        om_next = om_reg; xq_next = xq_reg; a_next = a_reg; p1_next = p1_reg;
        p2_next = p2_reg; div_idx_next = div_idx_reg;
        dstart = 1'b0; dnum = '0; dden = '0; q_ready = 1'b0;
        if (ov_reg && m_ready) ov_next = 1'b0;
        case (st_reg)
            est_pkg::ST_IDLE: begin
                if (q_valid && !ov_reg) begin
                    q_ready = 1'b1;
                    xq_next = XW'({q_x, {X_FRAC_BITS{1'b0}}});
                    lts_next = q_ts;
                    div_idx_next = 1'b0;
                    a_next = ALPHA_ROM[ALPHA_ENTRIES-1];
                    if (q_cls == est_pkg::CLS_HELD) begin
                        mode_next = est_pkg::MODE_HELD;
                    end else if (q_cls == est_pkg::CLS_FIRST) begin
                        f_next = XW'({q_x, {X_FRAC_BITS{1'b0}}});
                        mode_next = est_pkg::MODE_FIRST;
                        if (frame_width == '0) begin
                            hl_next = est_pkg::POWER_ONE;
                            hr_next = '0;
                        end else begin
                            dstart = 1'b1;
                            div_idx_next = 1'b1;
                            // rounded ratio: add half the frame width
                            dnum = {20'd0, q_x, 16'd0} + {37'd0, frame_width[11:1]};
                            dden = {20'd0, frame_width};
                        end
                    end else if (time_constant != '0) begin
                        dstart = 1'b1;
                        dnum = 48'({q_ts - lts_reg, 5'd0});
                        dden = {8'd0, time_constant};
                    end
                end
            end
            est_pkg::ST_IDX: begin
                if (ddone) begin
                    if (dquo > 48'(ALPHA_ENTRIES - 1)) a_next = ALPHA_ROM[ALPHA_ENTRIES-1];
                    else a_next = ALPHA_ROM[dquo[AIW-1:0]];
                end
            end
            est_pkg::ST_MUL: begin
                p1_next = (XW+17)'(f_reg) * (XW+17)'(17'd65536 - a_reg);
                p2_next = (XW+17)'(xq_reg) * (XW+17)'(a_reg);
            end
            est_pkg::ST_SUM: begin
                f_next = fn;
                div_idx_next = 1'b0;
                if (fn != '0 && {1'b0, fn} < wq) begin
                    if (((wq > {fn, 1'b0}) ? wq - {fn, 1'b0} : {fn, 1'b0} - wq) <= band) begin
                        hl_next = est_pkg::POWER_HALF; hr_next = est_pkg::POWER_HALF;
                        f_next = xq_reg;
                        mode_next = est_pkg::MODE_DEADBAND;
                    end else begin
                        mode_next = est_pkg::MODE_TRACK;
                        dstart = 1'b1;
                        div_idx_next = 1'b1;
                        dnum = 48'({fn, 16'd0} + (NW)'(wq >> 1));
                        dden = 32'(wq);
                    end
                end else begin
                    hl_next = est_pkg::POWER_HALF; hr_next = est_pkg::POWER_HALF;
                    mode_next = est_pkg::MODE_OUT;
                end
            end
            est_pkg::ST_DIV: begin
                if (ddone && div_idx_reg) begin
                    if (rq > 48'd65536) hl_next = est_pkg::POWER_ONE;
                    else hl_next = rq[16:0];
                    hr_next = est_pkg::POWER_ONE - ((rq > 48'd65536) ? est_pkg::POWER_ONE : rq[16:0]);
                end
            end
            est_pkg::ST_OUT: begin
                ov_next = 1'b1;
                ol_next = hl_reg; or_next = hr_reg; om_next = mode_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= est_pkg::ST_IDLE;
            f_reg <= '0; lts_reg <= '0; hl_reg <= '0; hr_reg <= '0;
            ov_reg <= 1'b0; div_idx_reg <= 1'b0; mode_reg <= '0;
        end else begin
            st_reg <= st_next;
            f_reg <= f_next; lts_reg <= lts_next; hl_reg <= hl_next; hr_reg <= hr_next;
            ov_reg <= ov_next; div_idx_reg <= div_idx_next; mode_reg <= mode_next;
        end
        ol_reg <= ol_next; or_reg <= or_next; om_reg <= om_next;
        xq_reg <= xq_next; a_reg <= a_next; p1_reg <= p1_next; p2_reg <= p2_next;
    end

    // powers sum to one, except the all-zero hold left by reset
    `EST_ASSERT_IMP(a_sum_one, aclk, aresetn, ov_reg, (ol_reg + or_reg) == est_pkg::POWER_ONE || (ol_reg | or_reg) == '0)
    `EST_ASSERT_NXT(a_out_valid, aclk, aresetn, st_reg == est_pkg::ST_OUT, ov_reg)
    `EST_ASSERT_IMP(a_no_take_busy, aclk, aresetn, q_ready, st_reg == est_pkg::ST_IDLE && !ov_reg)
endmodule

// File: rtl/ema_steering_thrust_split_core.sv
// top level of the ema steering thrust split block
// depends on est_pkg, est_front, est_back, est_div
// items run one at a time: the front takes an item only while the back is idle and
// the one-entry queue is empty; a tracking item runs two 48-step serial divisions,
// dt*32/time_constant for the alpha rom index and then the q1.16 power ratio, a
// deadband or out-of-frame item only the index division, a first acquire only the
// ratio, and a held item or a first acquire at zero frame width none; a zero time
// constant skips the index division; the next item is taken as soon as the result
// appears, even while that result waits on m_ready, though the back holds it in the
// queue until the result is taken; configuration is an apb register file
module ema_steering_thrust_split_core #(
    parameter int ALPHA_ENTRIES = est_pkg::ALPHA_ENTRIES_DEF,
    parameter int X_FRAC_BITS = est_pkg::X_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_x_coord,
    input  logic [31:0] s_timestamp,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_left_power,
    output logic [16:0] m_right_power,
    output logic [2:0]  m_mode
);
    localparam int XW = 12 + X_FRAC_BITS;

    // configuration registers
    logic [11:0] fw_reg;
    logic [23:0] tc_reg;
    logic [10:0] db_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= 12'd640;
            tc_reg <= 24'd1000;
            db_reg <= 11'd5;
        end else if (wr) begin
            case (paddr[3:2])
                est_pkg::ADDR_FRAME_WIDTH: fw_reg <= pwdata[11:0];
                est_pkg::ADDR_TIME_CONST: tc_reg <= pwdata[23:0];
                est_pkg::ADDR_DEADBAND: db_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            est_pkg::ADDR_FRAME_WIDTH: prdata = {20'd0, fw_reg};
            est_pkg::ADDR_TIME_CONST: prdata = {8'd0, tc_reg};
            est_pkg::ADDR_DEADBAND: prdata = {21'd0, db_reg};
            default: prdata = '0;
        endcase
    end

    // front to back queue
    logic          q_valid, q_ready, busy;
    est_pkg::cls_t q_cls;
    logic [11:0]   q_x;
    logic [31:0]   q_ts;
    logic [XW-1:0] filt_x;

    est_front #(.XW(XW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_x(s_x_coord), .in_ts(s_timestamp), .filt_x(filt_x), .filt_busy(busy),
        .q_valid(q_valid), .q_ready(q_ready), .q_cls(q_cls), .q_x(q_x), .q_ts(q_ts)
    );

    est_back #(.ALPHA_ENTRIES(ALPHA_ENTRIES), .X_FRAC_BITS(X_FRAC_BITS), .XW(XW)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_cls(q_cls), .q_x(q_x), .q_ts(q_ts), .frame_width(fw_reg),
        .time_constant(tc_reg), .deadband(db_reg), .filt_x(filt_x), .filt_busy(busy),
        .m_valid(m_valid), .m_ready(m_ready), .m_left(m_left_power),
        .m_right(m_right_power), .m_mode(m_mode)
    );
endmodule
